@@ rtl/bcc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types of the button click classifier.
package bcc_pkg;

	// Block sizing.
	localparam int BUTTON_COUNT  = 4;
	localparam int MASK_BITS     = 4;
	localparam int BTN_IDX_BITS  = 2;
	localparam int TIME_BITS     = 32;
	localparam int LANE_BITS     = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	// Timing constants in milliseconds.
	localparam logic [LANE_BITS-1:0] DEFAULT_DELAY = LANE_BITS'(500);
	localparam logic [LANE_BITS-1:0] MIN_INTERVAL  = LANE_BITS'(30);

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_EN    = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_EN   = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_EN     = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_REPORT = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] CFG_REL_REPORT  = CFG_IDX_BITS'(4);
	localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_DELAYS = CFG_IDX_BITS'(5);
	localparam logic [CFG_IDX_BITS-1:0] CFG_REP_INTVLS  = CFG_IDX_BITS'(6);

	// Whole configuration of the block.
	typedef struct packed {
		logic [MASK_BITS-1:0]     click_en;
		logic [MASK_BITS-1:0]     repeat_en;
		logic [MASK_BITS-1:0]     long_en;
		logic [MASK_BITS-1:0]     long_report;
		logic [MASK_BITS-1:0]     release_report;
		logic [CFG_DATA_BITS-1:0] long_delays;
		logic [CFG_DATA_BITS-1:0] repeat_intervals;
	} bcc_cfg_t;

	// Configuration seen by one button slice.
	typedef struct packed {
		logic                 click_en;
		logic                 repeat_en;
		logic                 long_en;
		logic                 long_report;
		logic                 release_report;
		logic [LANE_BITS-1:0] delay;
		logic [LANE_BITS-1:0] interval;
	} bcc_lane_cfg_t;

	// Stored state of one button.
	typedef struct packed {
		logic                 down;
		logic                 done;
		logic [TIME_BITS-1:0] edge_time;
		logic [TIME_BITS-1:0] last_repeat;
	} bcc_btn_state_t;

	// Events of one button in one poll.
	typedef struct packed {
		logic click;
		logic repeat_ev;
		logic long_press;
		logic long_release;
	} bcc_fire_t;

endpackage

@@ rtl/button_click_classifier.sv @@
`timescale 1ns / 1ps
// Top level of the button click classifier: poll register, slices, result register.
//
// Usage: each input transaction is one poll carrying now_ms and, when
// edge_valid is set, one press or release edge for button_index. Every poll
// yields exactly one output transaction with the per-button click, repeat,
// long press and long release events and the pop request of button 0.
// Both channels use valid and stall; a transaction moves at a rising edge with
// valid high and stall low. Configuration is written through cfg_valid,
// cfg_ready, cfg_index and cfg_data; cfg_ready is always high, and writes are
// expected only while no poll is in flight.
// A poll passes the poll register and then the result register on its way to
// the output; out_valid rises once the poll has reached the result register.
// Throughput is one poll per cycle while the receiver does not stall, set by
// the single pass of the four button slices between the two registers, which
// also update the button state.
// When the receiver stalls, the result register holds its transaction and the
// poll register still takes one more poll; in_stall rises only when both hold.
// Reset empties both registers and clears all button state and the
// configuration (long delays return to 500 ms per button).
module button_click_classifier import bcc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     edge_valid,
	input  logic [BTN_IDX_BITS-1:0]  button_index,
	input  logic                     pressed,
	input  logic [TIME_BITS-1:0]     now_ms,
	// Output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [MASK_BITS-1:0]     click_fired,
	output logic [MASK_BITS-1:0]     repeat_fired,
	output logic [MASK_BITS-1:0]     long_press_fired,
	output logic [MASK_BITS-1:0]     long_release_fired,
	output logic                     pop_request,
	// Configuration channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	bcc_cfg_t cfg;

	logic                    valid_s1;
	logic                    edge_valid_s1;
	logic [BTN_IDX_BITS-1:0] button_index_s1;
	logic                    pressed_s1;
	logic [TIME_BITS-1:0]    now_s1;
	logic                    advance;

	bcc_btn_state_t state_q    [BUTTON_COUNT];
	bcc_btn_state_t state_next [BUTTON_COUNT];
	bcc_fire_t      fire       [BUTTON_COUNT];

	logic [MASK_BITS-1:0] click_d;
	logic [MASK_BITS-1:0] repeat_d;
	logic [MASK_BITS-1:0] long_d;
	logic [MASK_BITS-1:0] release_d;
	logic                 pop_d;

	logic                 out_valid_q;
	logic [MASK_BITS-1:0] click_q;
	logic [MASK_BITS-1:0] repeat_q;
	logic [MASK_BITS-1:0] long_q;
	logic [MASK_BITS-1:0] release_q;
	logic                 pop_q;

	// Configuration registers.
	bcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The poll moves on whenever the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Poll register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			edge_valid_s1   <= edge_valid;
			button_index_s1 <= button_index;
			pressed_s1      <= pressed;
			now_s1          <= now_ms;
		end
	end

	// One slice per button.
	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_btn
		bcc_lane_cfg_t lane_cfg;
		logic          hit;

		always_comb begin
			lane_cfg.click_en       = cfg.click_en[b];
			lane_cfg.repeat_en      = cfg.repeat_en[b];
			lane_cfg.long_en        = cfg.long_en[b];
			lane_cfg.long_report    = cfg.long_report[b];
			lane_cfg.release_report = cfg.release_report[b];
			lane_cfg.delay          = cfg.long_delays[b*LANE_BITS +: LANE_BITS];
			lane_cfg.interval       = cfg.repeat_intervals[b*LANE_BITS +: LANE_BITS];
			hit = edge_valid_s1 && (button_index_s1 == BTN_IDX_BITS'(b))
				&& (state_q[b].down != pressed_s1);
		end

		bcc_slice u_slice (
			.lane_cfg   (lane_cfg),
			.state      (state_q[b]),
			.hit        (hit),
			.pressed    (pressed_s1),
			.now        (now_s1),
			.state_next (state_next[b]),
			.fire       (fire[b])
		);

		// Button state advances with each poll.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				state_q[b] <= '0;
			end else if (advance) begin
				state_q[b] <= state_next[b];
			end
		end
	end

	// Gather event bits; buttons beyond the count stay quiet.
	always_comb begin
		click_d   = '0;
		repeat_d  = '0;
		long_d    = '0;
		release_d = '0;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			click_d[b]   = fire[b].click;
			repeat_d[b]  = fire[b].repeat_ev;
			long_d[b]    = fire[b].long_press;
			release_d[b] = fire[b].long_release;
		end
		pop_d = state_next[0].down && !fire[0].click;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			click_q   <= click_d;
			repeat_q  <= repeat_d;
			long_q    <= long_d;
			release_q <= release_d;
			pop_q     <= pop_d;
		end
	end

	assign out_valid          = out_valid_q;
	assign click_fired        = click_q;
	assign repeat_fired       = repeat_q;
	assign long_press_fired   = long_q;
	assign long_release_fired = release_q;
	assign pop_request        = pop_q;

	// A poll that moves on always shows up as a result in the next cycle.
	a_advance_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("poll advanced but no result appeared");

	// The input side only stalls when a poll is waiting in the poll register.
	a_stall_needs_poll: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free pipeline");

	// A button cannot press long and release long in the same poll.
	a_long_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((long_q & release_q) == '0))
		else $error("long press and long release in one poll");

	// Click and autorepeat are exclusive per button.
	a_click_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((click_q & repeat_q) == '0))
		else $error("click and repeat in one poll");

	// A pop request never goes with a click on the back button.
	a_pop_no_click: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pop_q) |-> !click_q[0])
		else $error("pop request together with back click");

endmodule

@@ rtl/bcc_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file of the button click classifier.
module bcc_cfg import bcc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output bcc_cfg_t                 cfg
);

	bcc_cfg_t cfg_q;

	// Writes are taken in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg        = cfg_q;

	// Register write decode; unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_en         <= '0;
			cfg_q.repeat_en        <= '0;
			cfg_q.long_en          <= '0;
			cfg_q.long_report      <= '0;
			cfg_q.release_report   <= '0;
			cfg_q.long_delays      <= {(CFG_DATA_BITS / LANE_BITS){DEFAULT_DELAY}};
			cfg_q.repeat_intervals <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CLICK_EN:    cfg_q.click_en         <= cfg_data[MASK_BITS-1:0];
				CFG_REPEAT_EN:   cfg_q.repeat_en        <= cfg_data[MASK_BITS-1:0];
				CFG_LONG_EN:     cfg_q.long_en          <= cfg_data[MASK_BITS-1:0];
				CFG_LONG_REPORT: cfg_q.long_report      <= cfg_data[MASK_BITS-1:0];
				CFG_REL_REPORT:  cfg_q.release_report   <= cfg_data[MASK_BITS-1:0];
				CFG_LONG_DELAYS: cfg_q.long_delays      <= cfg_data;
				CFG_REP_INTVLS:  cfg_q.repeat_intervals <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/bcc_slice.sv @@
`timescale 1ns / 1ps
// Per-button classification slice: edge capture, long press and long release, autorepeat, click.
module bcc_slice import bcc_pkg::*; (
	input  bcc_lane_cfg_t        lane_cfg,
	input  bcc_btn_state_t       state,
	input  logic                 hit,
	input  logic                 pressed,
	input  logic [TIME_BITS-1:0] now,
	output bcc_btn_state_t       state_next,
	output bcc_fire_t            fire
);

	logic                 down;
	logic [TIME_BITS-1:0] etime;
	logic                 rep_en;
	logic                 click_en;
	logic [LANE_BITS-1:0] delay;
	logic [TIME_BITS-1:0] held;
	logic [TIME_BITS-1:0] since;

	// Apply the edge of this poll and derive the effective settings.
	always_comb begin
		down     = hit ? pressed : state.down;
		etime    = hit ? now : state.edge_time;
		rep_en   = lane_cfg.repeat_en && (lane_cfg.interval >= MIN_INTERVAL);
		click_en = lane_cfg.click_en || (lane_cfg.repeat_en && !rep_en);
		delay    = (lane_cfg.delay == '0) ? DEFAULT_DELAY : lane_cfg.delay;
		held     = now - etime;
		since    = now - state.last_repeat;
	end

	// Event decision and state update.
	always_comb begin
		state_next.down        = down;
		state_next.done        = state.done;
		state_next.edge_time   = etime;
		state_next.last_repeat = state.last_repeat;
		fire                   = '0;
		if (down) begin
			if (lane_cfg.long_en) begin
				if ((held > {{(TIME_BITS-LANE_BITS){1'b0}}, delay}) && !state.done) begin
					state_next.done = 1'b1;
					fire.long_press = lane_cfg.long_report;
				end
			end else if (rep_en) begin
				if (since > {{(TIME_BITS-LANE_BITS){1'b0}}, lane_cfg.interval}) begin
					fire.repeat_ev         = 1'b1;
					state_next.last_repeat = now;
				end
			end else if (click_en) begin
				fire.click = 1'b1;
			end
		end else begin
			if (lane_cfg.long_en && state.done) begin
				fire.long_release = lane_cfg.release_report;
				state_next.done   = 1'b0;
			end else if (lane_cfg.long_en && click_en && hit) begin
				fire.click = 1'b1;
			end
		end
	end

endmodule
